// File: rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int OCC_W = 6;

    typedef struct packed {
        logic               command;
        logic signed [31:0] key;
        logic        [31:0] payload;
    } spq_req_t;

    typedef struct packed {
        logic signed [31:0] out_key;
        logic        [31:0] out_payload;
        logic        [1:0]  status;
        logic [OCC_W-1:0]   occupancy;
    } spq_rsp_t;

    // One stored entry
    typedef struct packed {
        logic signed [31:0] key;
        logic        [31:0] payload;
    } spq_entry_t;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
    } spq_ctl_t;

endpackage

`default_nettype wire

// File: rtl/spq_cell.sv
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic       clk,
    input  wire spq_ctl_t   ctl,
    input  wire logic       occupied,
    input  wire spq_entry_t new_entry,
    input  wire spq_entry_t left_entry,
    input  wire logic       left_le,
    input  wire spq_entry_t right_entry,
    output spq_entry_t      entry,
    output logic            le
);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // Stored key sorts at or before the new key: this cell stays put on insert
    assign le    = occupied && (entry_reg.key <= new_entry.key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert && !le)
        begin
            // First cell past the insertion point takes the new entry,
            // the ones after it shift one place toward the tail
            entry_next = left_le ? new_entry : left_entry;
        end
        else if (ctl.remove)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
`default_nettype none

// Channel   Ports               Handshake
// -------   -----------------   ------------------------------------------
// command   start, busy, req    transaction taken when start && !busy
// result    done, rsp           rsp valid for the one cycle done is high
//
// Each result shows up on the cycle after its transaction, and a new
// command can be taken every cycle, so busy stays low. The rate is set
// by the row of cells, which all compare against the new key in parallel
// and shift in one step.
// Reset clears the entry count and the result strobe; cell contents are
// left undefined and only cells below the count are ever looked at.
// The receiver cannot stall; a result not taken in its cycle is gone.

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire spq_req_t req,
    output logic          done,
    output spq_rsp_t      rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             done_next;
    spq_rsp_t         rsp_reg;
    spq_rsp_t         rsp_next;

    spq_ctl_t   ctl;
    spq_entry_t new_entry;
    spq_entry_t cell_entry [CAPACITY];
    logic       cell_le    [CAPACITY];

    logic accept;
    logic is_full;
    logic is_empty;

    // Commands never hold off the requester
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign new_entry.key     = req.key;
    assign new_entry.payload = req.payload;

    // Drop refused commands before they reach the cells
    assign ctl.insert = accept && (req.command == CMD_INSERT) && !is_full;
    assign ctl.remove = accept && (req.command == CMD_DELETE) && !is_empty;

    // Row of cells: head at index 0 holds the smallest key
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_entry_t left_entry;
        logic       left_le;
        spq_entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_entry = new_entry;
            assign left_le    = 1'b1;
        end
        else
        begin : g_mid
            assign left_entry = cell_entry[i-1];
            assign left_le    = cell_le[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            // Tail slot empties on delete; its contents no longer matter
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (CNT_W'(i) < count_reg),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .left_le     (left_le),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .le          (cell_le[i])
        );
    end

    // Advance the count and build the result for this transaction
    always_comb
    begin
        count_next           = count_reg;
        done_next            = accept;
        rsp_next             = rsp_reg;
        if (accept)
        begin
            rsp_next.out_key     = '0;
            rsp_next.out_payload = '0;
            rsp_next.status      = ST_OK;
            case (req.command)
                CMD_INSERT:
                begin
                    if (is_full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_DELETE:
                begin
                    if (is_empty)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        rsp_next.out_key     = cell_entry[0].key;
                        rsp_next.out_payload = cell_entry[0].payload;
                        count_next           = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    rsp_next.status = ST_OK;
                end
            endcase
            rsp_next.occupancy = OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire
